>>> src/ctc_pkg.sv
// Package for the C token classifier: item and result types, lexer modes,
// character constants, keyword table and operator lookup functions.
// No dependencies.
`timescale 1ns / 1ps

package ctc_pkg;

    localparam int MATCH_BUFFER_BYTES_DEF = 8;
    localparam int LENGTH_LIMIT_DEF       = 255;
    localparam int MID_DEPTH              = 4;
    localparam int OUT_DEPTH              = 4;
    localparam int KW_COUNT               = 32;
    localparam int KW_MAX_LEN             = 8;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;

    typedef enum logic [2:0] {
        CLS_NUMBER      = 3'd0,
        CLS_KEYWORD     = 3'd1,
        CLS_IDENT       = 3'd2,
        CLS_BAD_IDENT   = 3'd3,
        CLS_STRING      = 3'd4,
        CLS_OPEN_STRING = 3'd5,
        CLS_OPERATOR    = 3'd6
    } t_tok_class;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_WORD   = 3'd1,
        MODE_OPER   = 3'd2,
        MODE_STRING = 3'd3,
        MODE_LINE   = 3'd4,
        MODE_BLOCK  = 3'd5,
        MODE_STAR   = 3'd6
    } t_mode;

    typedef struct packed {
        logic [7:0] code;
        logic       eoi;
        logic       blank;
        logic       quote;
        logic       op;
        logic       digit;
        logic       wordc;
    } t_byte_item;

    typedef struct packed {
        t_tok_class cls;
        logic [7:0] first;
        logic [7:0] len;
    } t_token;

    typedef struct packed {
        logic idle;
        logic count_zero;
    } t_back_stat;

    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        "auto", "break", "case", "char", "const", "continue", "default", "do",
        "double", "else", "enum", "extern", "float", "for", "goto", "if",
        "int", "long", "register", "return", "short", "signed", "sizeof", "static",
        "struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
        4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
        4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5
    };

    function automatic logic is_op_byte(input logic [7:0] c);
        logic r;
        case (c)
            "(", ")", "{", "}", "[", "]", ".", "+", "-", "/", "*", "%", "\\",
            "=", "<", ">", "&", "|", "^", "~", "!", ";", ",", "?", ":": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_op_pair(input logic [7:0] a, input logic [7:0] b);
        logic r;
        case ({a, b})
            "++", "--", "+=", "-=", "*=", "/=", "%=", "==",
            "<=", ">=", "!=", "<<", ">>", "||", "&&", "->": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // bytes: byte 0 in bits [7:0]; n: bytes in the word, 1 to 8
    function automatic logic is_keyword(input logic [63:0] bytes, input logic [3:0] n);
        logic [63:0] w;
        logic        hit;
        w   = '0;
        hit = 1'b0;
        for (int i = 0; i < KW_MAX_LEN; i++) begin
            if (4'(i) < n) begin
                w = {w[55:0], bytes[i*8 +: 8]};
            end
        end
        for (int k = 0; k < KW_COUNT; k++) begin
            if (w == KW_TEXT[k] && n == KW_LEN[k]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

>>> src/ctc_fifo.sv
// Small synchronous queue with registered storage and fall-through head.
// Depends on nothing; used between front and back and on the result side.
`timescale 1ns / 1ps

module ctc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> src/ctc_front.sv
// Front part: classifies each accepted source byte for the lexer.
// Depends on ctc_pkg.
`timescale 1ns / 1ps

module ctc_front
    import ctc_pkg::*;
(
    input  logic       i_push,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_input,
    output logic       o_push,
    output t_byte_item o_item
);

    logic w_digit, w_alpha;

    assign w_digit = (i_char_code >= "0") && (i_char_code <= "9");
    assign w_alpha = ((i_char_code >= "A") && (i_char_code <= "Z")) ||
                     ((i_char_code >= "a") && (i_char_code <= "z"));

    assign o_push       = i_push;
    assign o_item.code  = i_char_code;
    assign o_item.eoi   = i_end_of_input;
    assign o_item.blank = (i_char_code == CH_SPACE) || (i_char_code == CH_TAB) ||
                          (i_char_code == CH_NEWLINE);
    assign o_item.quote = (i_char_code == CH_QUOTE);
    assign o_item.op    = is_op_byte(i_char_code);
    assign o_item.digit = w_digit;
    assign o_item.wordc = w_alpha || w_digit || (i_char_code == CH_UNDERSCORE);

endmodule

>>> src/ctc_back.sv
// Back part: lexer state machine, token buffer and keyword match.
// Consumes classified bytes and produces finished tokens. Depends on ctc_pkg.
`timescale 1ns / 1ps

module ctc_back
    import ctc_pkg::*;
#(
    parameter int MATCH_BUFFER_BYTES = MATCH_BUFFER_BYTES_DEF,
    parameter int LENGTH_LIMIT       = LENGTH_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_byte_item i_item,
    output logic       o_res_push,
    output t_token     o_res,
    output t_back_stat o_stat
);

    localparam int CW = $clog2(LENGTH_LIMIT + 1);
    localparam int IW = $clog2(MATCH_BUFFER_BYTES);

    t_mode       r_mode, n_mode;
    logic [7:0]  r_buf [MATCH_BUFFER_BYTES];
    logic [CW-1:0] r_count, n_count;
    logic        r_digits, n_digits;
    logic        r_ident, n_ident;

    logic          w_we;
    logic [IW-1:0] w_widx;
    logic [7:0]    w_wdata;
    logic [63:0]   w_kw_bytes;
    logic          w_kw;
    t_tok_class    w_word_cls;
    logic [CW-1:0] w_take_count;
    logic          w_take_wr;
    logic          w_start;
    logic [7:0]    c;

    assign c = i_item.code;

    always_comb begin
        for (int i = 0; i < KW_MAX_LEN; i++) begin
            w_kw_bytes[i*8 +: 8] = r_buf[i];
        end
    end

    assign w_kw = (r_count != '0) && (32'(r_count) <= KW_MAX_LEN) &&
                  is_keyword(w_kw_bytes, 4'(r_count));

    always_comb begin
        if (r_digits) begin
            w_word_cls = CLS_NUMBER;
        end else if (w_kw) begin
            w_word_cls = CLS_KEYWORD;
        end else if (r_ident) begin
            w_word_cls = CLS_IDENT;
        end else begin
            w_word_cls = CLS_BAD_IDENT;
        end
    end

    assign w_take_count = (r_count < CW'(LENGTH_LIMIT)) ? r_count + 1'b1 : r_count;
    assign w_take_wr    = (32'(r_count) < MATCH_BUFFER_BYTES);

    always_comb begin
        n_mode     = r_mode;
        n_count    = r_count;
        n_digits   = r_digits;
        n_ident    = r_ident;
        w_we       = 1'b0;
        w_widx     = IW'(r_count);
        w_wdata    = c;
        w_start    = 1'b0;
        o_res_push = 1'b0;
        o_res      = '{cls: CLS_OPERATOR, first: r_buf[0], len: 8'(r_count)};
        if (i_valid) begin
            if (i_item.eoi) begin
                case (r_mode)
                    MODE_WORD: begin
                        o_res_push = 1'b1;
                        o_res.cls  = w_word_cls;
                    end
                    MODE_OPER: begin
                        o_res_push = 1'b1;
                    end
                    MODE_STRING: begin
                        o_res_push  = 1'b1;
                        o_res.cls   = CLS_OPEN_STRING;
                        o_res.first = CH_QUOTE;
                    end
                    default: o_res_push = 1'b0;
                endcase
                n_mode   = MODE_IDLE;
                n_count  = '0;
                n_digits = 1'b0;
                n_ident  = 1'b0;
            end else begin
                case (r_mode)
                    MODE_LINE: begin
                        if (c == CH_NEWLINE) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_BLOCK: begin
                        if (c == CH_STAR) begin
                            n_mode = MODE_STAR;
                        end
                    end
                    MODE_STAR: begin
                        if (c == CH_SLASH) begin
                            n_mode = MODE_IDLE;
                        end else if (c != CH_STAR) begin
                            n_mode = MODE_BLOCK;
                        end
                    end
                    MODE_STRING: begin
                        w_we    = w_take_wr;
                        n_count = w_take_count;
                        if (i_item.quote) begin
                            o_res_push  = 1'b1;
                            o_res.cls   = CLS_STRING;
                            o_res.first = CH_QUOTE;
                            o_res.len   = 8'(w_take_count);
                            n_mode      = MODE_IDLE;
                            n_count     = '0;
                            n_digits    = 1'b0;
                            n_ident     = 1'b0;
                        end
                    end
                    MODE_WORD: begin
                        if (i_item.blank || i_item.op) begin
                            o_res_push = 1'b1;
                            o_res.cls  = w_word_cls;
                            w_start    = 1'b1;
                        end else begin
                            if (!i_item.digit) begin
                                n_digits = 1'b0;
                            end
                            if (!i_item.wordc) begin
                                n_ident = 1'b0;
                            end
                            w_we    = w_take_wr;
                            n_count = w_take_count;
                        end
                    end
                    MODE_OPER: begin
                        if (r_count == CW'(1) && r_buf[0] == CH_SLASH &&
                            (c == CH_SLASH || c == CH_STAR)) begin
                            n_mode  = (c == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                            n_count = '0;
                        end else if (r_count == CW'(1) && is_op_pair(r_buf[0], c)) begin
                            w_we    = w_take_wr;
                            n_count = w_take_count;
                        end else begin
                            o_res_push = 1'b1;
                            w_start    = 1'b1;
                        end
                    end
                    default: w_start = 1'b1;
                endcase
                if (w_start) begin
                    n_digits = 1'b0;
                    n_ident  = 1'b0;
                    if (i_item.blank) begin
                        n_mode  = MODE_IDLE;
                        n_count = '0;
                    end else begin
                        w_we    = 1'b1;
                        w_widx  = '0;
                        n_count = CW'(1);
                        if (i_item.quote) begin
                            n_mode = MODE_STRING;
                        end else if (i_item.op) begin
                            n_mode = MODE_OPER;
                        end else begin
                            n_mode   = MODE_WORD;
                            n_digits = i_item.digit;
                            n_ident  = i_item.wordc && !i_item.digit;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_count  <= '0;
            r_digits <= 1'b0;
            r_ident  <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_count  <= n_count;
            r_digits <= n_digits;
            r_ident  <= n_ident;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_buf[w_widx] <= w_wdata;
        end
    end

    assign o_stat.idle       = (r_mode == MODE_IDLE);
    assign o_stat.count_zero = (r_count == '0);

endmodule

>>> src/c_token_classifier.sv
// C token classifier, top level: front classifier, middle queue, lexer back
// part and result queue. Depends on ctc_pkg, ctc_fifo, ctc_front, ctc_back.
//
// Use: push one source byte per cycle on i_char_code while o_full is low; set
// i_end_of_input with a push to flush the pending token and return to idle.
// Finished tokens leave through a queue: while o_empty is low the oldest
// token sits on o_token_class, o_first_char and o_token_length, and i_pop
// takes it. Comments and blanks produce no token.
// Path: a pushed byte is stored in the middle queue; the lexer takes it from the
// queue head and writes any token it closes into the result queue (o_empty low).
// Throughput: one byte per cycle while the result queue is not full; the lexer
// state register closes its loop with the 32 keyword and 16 operator pair
// compares in parallel.
// When the receiver stalls, the result queue fills, the lexer holds, the
// middle queue fills and o_full rises; nothing is lost.
// Reset (synchronous, i_rst_n low): both queues empty, lexer idle, counts
// and flags zero. No clearing pass.
`timescale 1ns / 1ps

module c_token_classifier
    import ctc_pkg::*;
#(
    parameter int MATCH_BUFFER_BYTES = MATCH_BUFFER_BYTES_DEF,
    parameter int LENGTH_LIMIT       = LENGTH_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_input,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [2:0] o_token_class,
    output logic [7:0] o_first_char,
    output logic [7:0] o_token_length
);

    logic       w_front_push;
    t_byte_item w_front_item;
    logic       w_mid_empty;
    t_byte_item w_mid_item;
    logic       w_item_pop;
    logic       w_out_full;
    logic       w_res_push;
    t_token     w_res;
    t_token     w_head;
    t_back_stat w_stat;

    ctc_front u_front (
        .i_push         (i_push),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .o_push         (w_front_push),
        .o_item         (w_front_item)
    );

    ctc_fifo #(
        .WIDTH ($bits(t_byte_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_data  (w_front_item),
        .o_full  (o_full),
        .i_pop   (w_item_pop),
        .o_empty (w_mid_empty),
        .o_data  (w_mid_item)
    );

    assign w_item_pop = !w_mid_empty && !w_out_full;

    ctc_back #(
        .MATCH_BUFFER_BYTES (MATCH_BUFFER_BYTES),
        .LENGTH_LIMIT       (LENGTH_LIMIT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_item_pop),
        .i_item     (w_mid_item),
        .o_res_push (w_res_push),
        .o_res      (w_res),
        .o_stat     (w_stat)
    );

    ctc_fifo #(
        .WIDTH ($bits(t_token)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (w_head)
    );

    assign o_token_class  = w_head.cls;
    assign o_first_char   = w_head.first;
    assign o_token_length = w_head.len;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_out_full)
        else $error("result pushed into full queue");

    a_push_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> w_item_pop)
        else $error("result produced without a consumed byte");

    a_eoi_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_item_pop && w_mid_item.eoi) |=> (w_stat.idle && w_stat.count_zero))
        else $error("lexer not idle after end of input");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_token_class != 3'd7))
        else $error("result class out of range");

endmodule

>>> tb/sv/tb_c_token_classifier.sv
// Self-checking testbench for c_token_classifier: a directed table of bytes, then random
// C-like text in three idle phases; each token checked against a typed table row or a
// local lexer predictor. Depends on ctc_pkg and c_token_classifier.
`timescale 1ns / 1ps

module tb_c_token_classifier;
    import ctc_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 540;
    localparam int BUF_BYTES     = MATCH_BUFFER_BYTES_DEF;
    localparam int LEN_MAX       = LENGTH_LIMIT_DEF;
    localparam t_token NO_TOK    = '{CLS_NUMBER, 8'h00, 8'h00};

    typedef enum int {
        FR_KEYWORD, FR_IDENT, FR_NUMBER, FR_OPER, FR_STRING, FR_LINE_CMT,
        FR_BLOCK_CMT, FR_NOISE, FR_FLUSH, FR_BLANK, FR_LONG_WORD, FR_LONG_STRING
    } t_frag_kind;

    typedef struct {
        logic [7:0] code;
        logic       eoi;
        bit         typed;
        bit         hit;
        t_token     tok;
    } t_dir_row;

    typedef struct {
        logic [7:0] code;
        logic       eoi;
    } t_plan;

    logic       i_clk;
    logic       i_rst_n        = 1'b0;
    logic       i_push         = 1'b0;
    logic [7:0] i_char_code    = 8'h00;
    logic       i_end_of_input = 1'b0;
    logic       i_pop          = 1'b0;
    logic       o_full;
    logic       o_empty;
    logic [2:0] o_token_class;
    logic [7:0] o_first_char;
    logic [7:0] o_token_length;

    string kw_names [32] = '{
        "auto", "break", "case", "char", "const", "continue", "default", "do",
        "double", "else", "enum", "extern", "float", "for", "goto", "if",
        "int", "long", "register", "return", "short", "signed", "sizeof", "static",
        "struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"
    };
    string op_chars = "(){}[].+-/*%\\=<>&|^~!;,?:";
    string op_pairs [16] = '{
        "++", "--", "+=", "-=", "*=", "/=", "%=", "==",
        "<=", ">=", "!=", "<<", ">>", "||", "&&", "->"
    };
    string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

    t_dir_row dir_rows [30] = '{
        '{"i",        1'b0, 1'b1, 1'b0, NO_TOK},
        '{"f",        1'b0, 1'b1, 1'b0, NO_TOK},
        '{" ",        1'b0, 1'b1, 1'b1, '{CLS_KEYWORD, "i", 8'd2}},
        '{8'hFF,      1'b0, 1'b1, 1'b0, NO_TOK},
        '{8'h00,      1'b1, 1'b1, 1'b1, '{CLS_BAD_IDENT, 8'hFF, 8'd1}},
        '{"9",        1'b0, 1'b1, 1'b0, NO_TOK},
        '{"+",        1'b0, 1'b1, 1'b1, '{CLS_NUMBER, "9", 8'd1}},
        '{"=",        1'b0, 1'b1, 1'b0, NO_TOK},
        '{"/",        1'b0, 1'b1, 1'b1, '{CLS_OPERATOR, "+", 8'd2}},
        '{"*",        1'b0, 1'b1, 1'b0, NO_TOK},
        '{"*",        1'b0, 1'b1, 1'b0, NO_TOK},
        '{"*",        1'b0, 1'b1, 1'b0, NO_TOK},
        '{"/",        1'b0, 1'b1, 1'b0, NO_TOK},
        '{CH_QUOTE,   1'b0, 1'b1, 1'b0, NO_TOK},
        '{"\\",       1'b0, 1'b1, 1'b0, NO_TOK},
        '{CH_QUOTE,   1'b0, 1'b1, 1'b1, '{CLS_STRING, CH_QUOTE, 8'd3}},
        '{"/",        1'b0, 1'b1, 1'b0, NO_TOK},
        '{"/",        1'b0, 1'b1, 1'b0, NO_TOK},
        '{CH_NEWLINE, 1'b0, 1'b1, 1'b0, NO_TOK},
        '{"_",        1'b0, 1'b0, 1'b0, NO_TOK},
        '{CH_QUOTE,   1'b0, 1'b0, 1'b0, NO_TOK},
        '{CH_TAB,     1'b0, 1'b0, 1'b0, NO_TOK},
        '{"x",        1'b0, 1'b0, 1'b0, NO_TOK},
        '{"-",        1'b0, 1'b0, 1'b0, NO_TOK},
        '{">",        1'b0, 1'b0, 1'b0, NO_TOK},
        '{8'hFF,      1'b1, 1'b0, 1'b0, NO_TOK},
        '{8'hFF,      1'b1, 1'b1, 1'b0, NO_TOK},
        '{CH_QUOTE,   1'b0, 1'b0, 1'b0, NO_TOK},
        '{"a",        1'b0, 1'b0, 1'b0, NO_TOK},
        '{8'h00,      1'b1, 1'b1, 1'b1, '{CLS_OPEN_STRING, CH_QUOTE, 8'd2}}
    };

    t_mode      lex_mode            = MODE_IDLE;
    logic [7:0] lex_buf [BUF_BYTES] = '{default: 8'h00};
    int         lex_count           = 0;
    bit         lex_digits          = 1'b0;
    bit         lex_ident           = 1'b0;

    t_token pending_tokens [$];
    t_plan  plan [$];
    int     fail_count    = 0;
    int     live_items    = 0;
    int     push_idle_pct = 19;
    int     pop_idle_pct  = 66;
    int     cycle_count   = 0;

    c_token_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_token_class  (o_token_class),
        .o_first_char   (o_first_char),
        .o_token_length (o_token_length)
    );

    function automatic bit blank_char(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE;
    endfunction

    function automatic bit digit_char(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit word_char(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || digit_char(c)
            || c == CH_UNDERSCORE;
    endfunction

    function automatic bit op_char(logic [7:0] c);
        bit found;
        found = 1'b0;
        for (int k = 0; k < op_chars.len(); k++) begin
            if (8'(op_chars[k]) == c) found = 1'b1;
        end
        return found;
    endfunction

    function automatic bit op_pair(logic [7:0] a, logic [7:0] b);
        bit found;
        found = 1'b0;
        for (int k = 0; k < 16; k++) begin
            if (8'(op_pairs[k][0]) == a && 8'(op_pairs[k][1]) == b) found = 1'b1;
        end
        return found;
    endfunction

    function automatic bit kw_match();
        bit found;
        bit same;
        found = 1'b0;
        if (lex_count == 0 || lex_count > 8 || lex_count > BUF_BYTES) return 1'b0;
        for (int k = 0; k < 32; k++) begin
            if (kw_names[k].len() == lex_count) begin
                same = 1'b1;
                for (int i = 0; i < lex_count; i++) begin
                    if (lex_buf[i] != 8'(kw_names[k][i])) same = 1'b0;
                end
                if (same) found = 1'b1;
            end
        end
        return found;
    endfunction

    function automatic void take_char(logic [7:0] c);
        if (lex_count < BUF_BYTES) lex_buf[lex_count] = c;
        if (lex_count < LEN_MAX) lex_count++;
    endfunction

    function automatic t_token word_token();
        t_token tok;
        if (lex_digits) tok.cls = CLS_NUMBER;
        else if (kw_match()) tok.cls = CLS_KEYWORD;
        else if (lex_ident) tok.cls = CLS_IDENT;
        else tok.cls = CLS_BAD_IDENT;
        tok.first = lex_buf[0];
        tok.len   = 8'(lex_count);
        return tok;
    endfunction

    function automatic void begin_token(logic [7:0] c);
        lex_count  = 0;
        lex_digits = 1'b0;
        lex_ident  = 1'b0;
        if (blank_char(c)) begin
            lex_mode = MODE_IDLE;
            return;
        end
        take_char(c);
        if (c == CH_QUOTE) begin
            lex_mode = MODE_STRING;
        end else if (op_char(c)) begin
            lex_mode = MODE_OPER;
        end else begin
            lex_mode   = MODE_WORD;
            lex_digits = digit_char(c);
            lex_ident  = word_char(c) && !digit_char(c);
        end
    endfunction

    function automatic bit lex_step(input logic [7:0] c, input logic e, output t_token tok);
        bit hit;
        hit = 1'b0;
        tok = NO_TOK;
        if (e) begin
            case (lex_mode)
                MODE_WORD: begin
                    tok = word_token();
                    hit = 1'b1;
                end
                MODE_OPER: begin
                    tok = '{CLS_OPERATOR, lex_buf[0], 8'(lex_count)};
                    hit = 1'b1;
                end
                MODE_STRING: begin
                    tok = '{CLS_OPEN_STRING, CH_QUOTE, 8'(lex_count)};
                    hit = 1'b1;
                end
                default: ;
            endcase
            lex_mode   = MODE_IDLE;
            lex_buf    = '{default: 8'h00};
            lex_count  = 0;
            lex_digits = 1'b0;
            lex_ident  = 1'b0;
            return hit;
        end
        case (lex_mode)
            MODE_LINE: begin
                if (c == CH_NEWLINE) lex_mode = MODE_IDLE;
            end
            MODE_BLOCK: begin
                if (c == CH_STAR) lex_mode = MODE_STAR;
            end
            MODE_STAR: begin
                if (c == CH_SLASH) lex_mode = MODE_IDLE;
                else if (c != CH_STAR) lex_mode = MODE_BLOCK;
            end
            MODE_STRING: begin
                take_char(c);
                if (c == CH_QUOTE) begin
                    tok = '{CLS_STRING, CH_QUOTE, 8'(lex_count)};
                    hit = 1'b1;
                    begin_token(CH_SPACE);
                end
            end
            MODE_WORD: begin
                if (blank_char(c) || op_char(c)) begin
                    tok = word_token();
                    hit = 1'b1;
                    begin_token(c);
                end else begin
                    if (!digit_char(c)) lex_digits = 1'b0;
                    if (!word_char(c)) lex_ident = 1'b0;
                    take_char(c);
                end
            end
            MODE_OPER: begin
                if (lex_count == 1 && lex_buf[0] == CH_SLASH
                        && (c == CH_SLASH || c == CH_STAR)) begin
                    lex_mode  = (c == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                    lex_count = 0;
                end else if (lex_count == 1 && op_pair(lex_buf[0], c)) begin
                    take_char(c);
                end else begin
                    tok = '{CLS_OPERATOR, lex_buf[0], 8'(lex_count)};
                    hit = 1'b1;
                    begin_token(c);
                end
            end
            default: begin
                begin_token(c);
            end
        endcase
        return hit;
    endfunction

    function automatic logic [7:0] pick_word_char();
        return 8'(word_chars[$urandom_range(word_chars.len() - 1)]);
    endfunction

    function automatic logic [7:0] pick_lead_char();
        int idx;
        idx = $urandom_range(52);
        return (idx == 52) ? CH_UNDERSCORE : 8'(word_chars[idx]);
    endfunction

    function automatic logic [7:0] pick_text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(2);
        return (r == 0) ? CH_SPACE : (r == 1) ? CH_TAB : CH_NEWLINE;
    endfunction

    function automatic void plan_char(logic [7:0] c);
        plan.push_back('{c, 1'b0});
    endfunction

    function automatic void build_fragment(t_frag_kind kind);
        int         k;
        int         n;
        logic [7:0] c;
        case (kind)
            FR_KEYWORD: begin
                k = $urandom_range(31);
                for (int i = 0; i < kw_names[k].len(); i++) plan_char(8'(kw_names[k][i]));
                if ($urandom_range(4) == 0) plan_char(pick_word_char());
            end
            FR_IDENT: begin
                plan_char(pick_lead_char());
                n = $urandom_range(11);
                repeat (n) plan_char(pick_word_char());
            end
            FR_NUMBER: begin
                n = $urandom_range(1, 10);
                repeat (n) plan_char(8'("0" + $urandom_range(9)));
            end
            FR_OPER: begin
                if ($urandom_range(1) == 0) begin
                    k = $urandom_range(15);
                    plan_char(8'(op_pairs[k][0]));
                    plan_char(8'(op_pairs[k][1]));
                end else begin
                    plan_char(8'(op_chars[$urandom_range(op_chars.len() - 1)]));
                end
            end
            FR_STRING: begin
                plan_char(CH_QUOTE);
                n = $urandom_range(12);
                repeat (n) plan_char(pick_text_char());
                if ($urandom_range(6) != 0) plan_char(CH_QUOTE);
            end
            FR_LINE_CMT: begin
                plan_char(CH_SLASH);
                plan_char(CH_SLASH);
                n = $urandom_range(10);
                repeat (n) begin
                    do c = 8'($urandom_range(255)); while (c == CH_NEWLINE);
                    plan_char(c);
                end
                if ($urandom_range(9) != 0) plan_char(CH_NEWLINE);
            end
            FR_BLOCK_CMT: begin
                plan_char(CH_SLASH);
                plan_char(CH_STAR);
                n = $urandom_range(10);
                repeat (n) plan_char(8'($urandom_range(255)));
                n = $urandom_range(1, 3);
                repeat (n) plan_char(CH_STAR);
                plan_char(CH_SLASH);
            end
            FR_NOISE: begin
                n = $urandom_range(1, 4);
                repeat (n) plan_char(8'($urandom_range(255)));
            end
            FR_FLUSH: begin
                plan.push_back('{8'($urandom_range(255)), 1'b1});
            end
            FR_BLANK: begin
                n = $urandom_range(1, 3);
                repeat (n) plan_char(pick_blank());
            end
            FR_LONG_WORD: begin
                plan_char(pick_lead_char());
                n = $urandom_range(250, 300);
                repeat (n) plan_char(pick_word_char());
            end
            FR_LONG_STRING: begin
                plan_char(CH_QUOTE);
                n = $urandom_range(250, 300);
                repeat (n) plan_char(pick_text_char());
                plan_char(CH_QUOTE);
            end
            default: ;
        endcase
        if (kind != FR_FLUSH && $urandom_range(9) < 6) plan_char(pick_blank());
    endfunction

    task automatic send_req(input logic [7:0] c, input logic e, input bit typed,
                            input bit t_hit, input t_token t_tok);
        t_token tok;
        bit     hit;
        while ($urandom_range(99) < push_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push         <= 1'b1;
        i_char_code    <= c;
        i_end_of_input <= e;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        if (e || !(lex_mode inside {MODE_LINE, MODE_BLOCK, MODE_STAR})) live_items++;
        hit = lex_step(c, e, tok);
        if (typed) begin
            hit = t_hit;
            tok = t_tok;
        end
        if (hit) pending_tokens.push_back(tok);
    endtask

    task automatic drive_plan();
        t_plan p;
        while (plan.size() != 0) begin
            p = plan.pop_front();
            send_req(p.code, p.eoi, 1'b0, 1'b0, NO_TOK);
        end
    endtask

    task automatic wait_all_tokens();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (pending_tokens.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(int push_pct, int pop_pct, t_frag_kind opener);
        int         start;
        int         r;
        t_frag_kind kind;
        push_idle_pct = push_pct;
        pop_idle_pct  = pop_pct;
        start         = live_items;
        build_fragment(opener);
        drive_plan();
        while (live_items - start < PHASE_ITEMS) begin
            r = $urandom_range(199);
            if (r < 1) kind = FR_LONG_WORD;
            else if (r < 2) kind = FR_LONG_STRING;
            else if (r < 32) kind = FR_KEYWORD;
            else if (r < 62) kind = FR_IDENT;
            else if (r < 82) kind = FR_NUMBER;
            else if (r < 112) kind = FR_OPER;
            else if (r < 130) kind = FR_STRING;
            else if (r < 140) kind = FR_LINE_CMT;
            else if (r < 150) kind = FR_BLOCK_CMT;
            else if (r < 170) kind = FR_NOISE;
            else if (r < 178) kind = FR_FLUSH;
            else kind = FR_BLANK;
            build_fragment(kind);
            drive_plan();
        end
        wait_all_tokens();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count == LIMIT_CYCLES) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : result_check
        t_token want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_pop && !o_empty) begin
                if (pending_tokens.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: unexpected token class %0d first %h length %0d",
                                 $time, o_token_class, o_first_char, o_token_length);
                    end
                    fail_count++;
                end else begin
                    want = pending_tokens.pop_front();
                    if (o_token_class !== want.cls || o_first_char !== want.first
                            || o_token_length !== want.len) begin
                        if (fail_count < 10) begin
                            $display("%0t: token mismatch: expected %0d/%h/%0d, got %0d/%h/%0d",
                                     $time, want.cls, want.first, want.len,
                                     o_token_class, o_first_char, o_token_length);
                        end
                        fail_count++;
                    end
                end
            end
            i_pop <= ($urandom_range(99) >= pop_idle_pct);
        end
    end

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].code, dir_rows[i].eoi, dir_rows[i].typed,
                     dir_rows[i].hit, dir_rows[i].tok);
        end
        wait_all_tokens();
        run_phase(19, 66, FR_LONG_WORD);
        run_phase(66, 19, FR_LONG_STRING);
        run_phase(0, 0, FR_KEYWORD);
        build_fragment(FR_FLUSH);
        drive_plan();
        wait_all_tokens();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_tokens.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
src/ctc_pkg.sv
src/ctc_fifo.sv
src/ctc_front.sv
src/ctc_back.sv
src/c_token_classifier.sv
tb/sv/tb_c_token_classifier.sv
